// ===== rtl/core/assert_macros.svh =====
// assertion macros for the rtl files of this block
// no dependencies; expects clk and arst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_HOLDS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/ocs_pkg.sv =====
// package of the orbit camera step unit: widths, microcode types, control store
// and fixed-point helpers; no dependencies
package ocs_pkg;

	// fixed-point format and derived widths
	localparam int FRAC_BITS = 16;
	localparam int Q_W       = 24;
	localparam int V_W       = 51;
	localparam int MAG_W     = 30;
	localparam int SUM_W     = 62;
	localparam int ROOT_W    = 63;
	localparam int LEN_W     = 31;
	localparam int NUM_W     = MAG_W + FRAC_BITS + 1;
	localparam int QUO_W     = FRAC_BITS + 1;
	localparam int CNT_W     = 5;
	localparam int PC_W      = 6;
	localparam int PROG_LEN  = 46;
	localparam int SQRT_STEPS = 32;

	// 0.01 rounded to nearest in the fraction format
	localparam int SCALE_K = ((1 << FRAC_BITS) + 50) / 100;

	// 1.0 and -1.0 clamped to the coordinate range
	localparam logic signed [Q_W-1:0] ONE_Q = (FRAC_BITS >= Q_W - 1) ?
		24'sh7FFFFF : Q_W'(64'sd1 <<< FRAC_BITS);
	localparam logic signed [Q_W-1:0] NEG_ONE_Q = (FRAC_BITS >= Q_W) ?
		24'sh800000 : Q_W'(-(64'sd1 <<< FRAC_BITS));

	// microcode fields
	typedef enum logic [3:0] {
		OP_NOP, OP_MAG, OP_RED, OP_SQI, OP_SQS, OP_DVI, OP_DVS,
		OP_CALL, OP_RET, OP_LDDIR, OP_DONE, OP_FAIL
	} op_t;

	typedef enum logic [2:0] {
		M_NONE, M_DXK, M_DYK, M_UFY, M_SFX, M_DU, M_SD, M_SQ
	} mul_t;

	typedef enum logic [3:0] {
		W_NONE, W_FDX, W_FDY, W_EUP, W_ESD, W_ACC, W_VSB, W_SQ0, W_SQA
	} wb_t;

	typedef enum logic [1:0] {
		D_SIDE, D_UPN, D_DIR
	} dst_t;

	typedef struct packed {
		op_t              op;
		mul_t             mul;
		wb_t              wb;
		logic [1:0]       ia;
		logic [1:0]       ib;
		dst_t             dst;
		logic [PC_W-1:0]  tgt;
	} ctl_t;

	// program labels
	localparam logic [PC_W-1:0] A_FAIL = 6'd30;
	localparam logic [PC_W-1:0] A_NORM = 6'd31;

	function automatic ctl_t mk(input op_t op, input mul_t mul, input wb_t wb,
		input logic [1:0] ia, input logic [1:0] ib, input dst_t dst,
		input logic [PC_W-1:0] tgt);
		ctl_t c;
		c.op  = op;
		c.mul = mul;
		c.wb  = wb;
		c.ia  = ia;
		c.ib  = ib;
		c.dst = dst;
		c.tgt = tgt;
		return c;
	endfunction

	// control store: main program, then the normalize subroutine
	function automatic ctl_t rom_word(input logic [PC_W-1:0] a);
		ctl_t c;
		unique case (a)
			6'd0:  c = mk(OP_NOP,  M_DXK,  W_NONE, 2'd0, 2'd0, D_SIDE, '0);
			6'd1:  c = mk(OP_NOP,  M_DYK,  W_FDX,  2'd0, 2'd0, D_SIDE, '0);
			6'd2:  c = mk(OP_NOP,  M_NONE, W_FDY,  2'd0, 2'd0, D_SIDE, '0);
			6'd3:  c = mk(OP_NOP,  M_UFY,  W_NONE, 2'd0, 2'd0, D_SIDE, '0);
			6'd4:  c = mk(OP_NOP,  M_UFY,  W_EUP,  2'd1, 2'd0, D_SIDE, '0);
			6'd5:  c = mk(OP_NOP,  M_UFY,  W_EUP,  2'd2, 2'd0, D_SIDE, '0);
			6'd6:  c = mk(OP_NOP,  M_NONE, W_EUP,  2'd2, 2'd0, D_SIDE, '0);
			6'd7:  c = mk(OP_NOP,  M_DU,   W_NONE, 2'd1, 2'd2, D_SIDE, '0);
			6'd8:  c = mk(OP_NOP,  M_DU,   W_ACC,  2'd2, 2'd1, D_SIDE, '0);
			6'd9:  c = mk(OP_NOP,  M_DU,   W_VSB,  2'd2, 2'd0, D_SIDE, '0);
			6'd10: c = mk(OP_NOP,  M_DU,   W_ACC,  2'd0, 2'd2, D_SIDE, '0);
			6'd11: c = mk(OP_NOP,  M_DU,   W_VSB,  2'd0, 2'd1, D_SIDE, '0);
			6'd12: c = mk(OP_NOP,  M_DU,   W_ACC,  2'd1, 2'd0, D_SIDE, '0);
			6'd13: c = mk(OP_NOP,  M_NONE, W_VSB,  2'd2, 2'd0, D_SIDE, '0);
			6'd14: c = mk(OP_CALL, M_NONE, W_NONE, 2'd0, 2'd0, D_SIDE, A_NORM);
			6'd15: c = mk(OP_NOP,  M_SFX,  W_NONE, 2'd0, 2'd0, D_SIDE, '0);
			6'd16: c = mk(OP_NOP,  M_SFX,  W_ESD,  2'd1, 2'd0, D_SIDE, '0);
			6'd17: c = mk(OP_NOP,  M_SFX,  W_ESD,  2'd2, 2'd0, D_SIDE, '0);
			6'd18: c = mk(OP_NOP,  M_NONE, W_ESD,  2'd2, 2'd0, D_SIDE, '0);
			6'd19: c = mk(OP_NOP,  M_SD,   W_NONE, 2'd1, 2'd2, D_SIDE, '0);
			6'd20: c = mk(OP_NOP,  M_SD,   W_ACC,  2'd2, 2'd1, D_SIDE, '0);
			6'd21: c = mk(OP_NOP,  M_SD,   W_VSB,  2'd2, 2'd0, D_SIDE, '0);
			6'd22: c = mk(OP_NOP,  M_SD,   W_ACC,  2'd0, 2'd2, D_SIDE, '0);
			6'd23: c = mk(OP_NOP,  M_SD,   W_VSB,  2'd0, 2'd1, D_SIDE, '0);
			6'd24: c = mk(OP_NOP,  M_SD,   W_ACC,  2'd1, 2'd0, D_SIDE, '0);
			6'd25: c = mk(OP_NOP,  M_NONE, W_VSB,  2'd2, 2'd0, D_SIDE, '0);
			6'd26: c = mk(OP_CALL, M_NONE, W_NONE, 2'd0, 2'd0, D_UPN, A_NORM);
			6'd27: c = mk(OP_LDDIR, M_NONE, W_NONE, 2'd0, 2'd0, D_SIDE, '0);
			6'd28: c = mk(OP_CALL, M_NONE, W_NONE, 2'd0, 2'd0, D_DIR, A_NORM);
			6'd29: c = mk(OP_DONE, M_NONE, W_NONE, 2'd0, 2'd0, D_SIDE, '0);
			6'd30: c = mk(OP_FAIL, M_NONE, W_NONE, 2'd0, 2'd0, D_SIDE, '0);
			6'd31: c = mk(OP_MAG,  M_NONE, W_NONE, 2'd0, 2'd0, D_SIDE, A_FAIL);
			6'd32: c = mk(OP_RED,  M_NONE, W_NONE, 2'd0, 2'd0, D_SIDE, '0);
			6'd33: c = mk(OP_NOP,  M_SQ,   W_NONE, 2'd0, 2'd0, D_SIDE, '0);
			6'd34: c = mk(OP_NOP,  M_SQ,   W_SQ0,  2'd1, 2'd0, D_SIDE, '0);
			6'd35: c = mk(OP_NOP,  M_SQ,   W_SQA,  2'd2, 2'd0, D_SIDE, '0);
			6'd36: c = mk(OP_NOP,  M_NONE, W_SQA,  2'd0, 2'd0, D_SIDE, '0);
			6'd37: c = mk(OP_SQI,  M_NONE, W_NONE, 2'd0, 2'd0, D_SIDE, '0);
			6'd38: c = mk(OP_SQS,  M_NONE, W_NONE, 2'd0, 2'd0, D_SIDE, '0);
			6'd39: c = mk(OP_DVI,  M_NONE, W_NONE, 2'd0, 2'd0, D_SIDE, '0);
			6'd40: c = mk(OP_DVS,  M_NONE, W_NONE, 2'd0, 2'd0, D_SIDE, '0);
			6'd41: c = mk(OP_DVI,  M_NONE, W_NONE, 2'd1, 2'd0, D_SIDE, '0);
			6'd42: c = mk(OP_DVS,  M_NONE, W_NONE, 2'd1, 2'd0, D_SIDE, '0);
			6'd43: c = mk(OP_DVI,  M_NONE, W_NONE, 2'd2, 2'd0, D_SIDE, '0);
			6'd44: c = mk(OP_DVS,  M_NONE, W_NONE, 2'd2, 2'd0, D_SIDE, '0);
			6'd45: c = mk(OP_RET,  M_NONE, W_NONE, 2'd0, 2'd0, D_SIDE, '0);
			default: c = mk(OP_FAIL, M_NONE, W_NONE, 2'd0, 2'd0, D_SIDE, '0);
		endcase
		return c;
	endfunction

	// clamp to the signed coordinate range
	function automatic logic signed [Q_W-1:0] sat_q(input logic signed [63:0] v);
		if (v > 64'sd8388607) begin
			return 24'sh7FFFFF;
		end else if (v < -64'sd8388608) begin
			return 24'sh800000;
		end
		return Q_W'(v);
	endfunction

	// shift a product down by the fraction bits, round half away from zero
	function automatic logic signed [63:0] rnd_q(input logic signed [63:0] p);
		logic [63:0] m;
		logic [63:0] r;
		m = (p < 0) ? 64'(-p) : 64'(p);
		r = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		return (p < 0) ? -$signed(r) : $signed(r);
	endfunction

endpackage

// ===== rtl/core/orbit_camera_step_unit.sv =====
// orbit camera step unit: microcoded sequencer over one shared multiplier,
// a bit-serial square root and a restoring divider; uses ocs_pkg and assert_macros.svh
// each item runs three normalize passes (32 square-root steps and three divisions of FRAC_BITS+1 steps each,
// plus magnitude reduction); a zero vector blocks the item and ends its run early
// throughput: one item at a time; the next item is taken once the result is registered
// reset: asynchronous active low; eye (0,0,-1), up (0,1,0), center 0, no result pending
`include "assert_macros.svh"

module orbit_camera_step_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic signed [15:0]   drag_x,
	input  logic signed [15:0]   drag_y,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic signed [23:0]   eye_x,
	output logic signed [23:0]   eye_y,
	output logic signed [23:0]   eye_z,
	output logic signed [23:0]   up_x,
	output logic signed [23:0]   up_y,
	output logic signed [23:0]   up_z,
	output logic                 degenerate,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [23:0]          cfg_data
);

	localparam int QW = ocs_pkg::Q_W;
	localparam int VW = ocs_pkg::V_W;
	localparam int MW = ocs_pkg::MAG_W;
	localparam int SW = ocs_pkg::SUM_W;
	localparam int RW = ocs_pkg::ROOT_W;
	localparam int LW = ocs_pkg::LEN_W;
	localparam int NW = ocs_pkg::NUM_W;
	localparam int UW = ocs_pkg::QUO_W;
	localparam int CW = ocs_pkg::CNT_W;
	localparam int PW = ocs_pkg::PC_W;
	localparam int FB = ocs_pkg::FRAC_BITS;

	// sequencer and state
	logic                  busy_q;
	logic [PW-1:0]         pc_q;
	logic [PW-1:0]         ret_q;
	ocs_pkg::dst_t         dst_q;
	logic                  out_valid_q;
	logic signed [QW-1:0]  eye_q [3];
	logic signed [QW-1:0]  up_q [3];
	logic signed [QW-1:0]  cen_q [3];

	// datapath registers
	logic signed [15:0]    dx_q, dy_q;
	logic signed [QW-1:0]  fdx_q, fdy_q;
	logic signed [QW-1:0]  e_q [3];
	logic signed [63:0]    p_q;
	logic [1:0]            wi_q;
	logic [1:0]            vi_q;
	logic signed [VW-1:0]  acc_q;
	logic signed [VW-1:0]  v_q [3];
	logic [VW-1:0]         m_q [3];
	logic                  sg_q [3];
	logic [SW-1:0]         sum_q;
	logic [SW-1:0]         x_q;
	logic [RW-1:0]         r_q;
	logic [NW-1:0]         num_q;
	logic [LW:0]           rem_q;
	logic [UW-1:0]         q_q;
	logic [CW-1:0]         cnt_q;
	logic signed [QW-1:0]  side_q [3];
	logic signed [QW-1:0]  upn_q [3];
	logic signed [QW-1:0]  dir_q [3];
	logic signed [QW-1:0]  out_eye_q [3];
	logic signed [QW-1:0]  out_up_q [3];
	logic                  out_deg_q;

	// combinational
	ocs_pkg::ctl_t         w;
	logic signed [QW:0]    d [3];
	logic signed [31:0]    mul_a, mul_b;
	logic signed [63:0]    prod;
	logic [RW-1:0]         sq_bit, sq_t;
	logic                  sq_ge;
	logic [LW-1:0]         len;
	logic [LW:0]           dv_t;
	logic                  dv_ge;
	logic [UW-1:0]         qn;
	logic signed [63:0]    qext;
	logic signed [QW-1:0]  div_val;
	logic [NW-1:0]         num_init;
	logic                  big, vzero, out_free;
	logic signed [QW-1:0]  new_eye [3];

	assign in_ready  = !busy_q;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign eye_x = out_eye_q[0];
	assign eye_y = out_eye_q[1];
	assign eye_z = out_eye_q[2];
	assign up_x  = out_up_q[0];
	assign up_y  = out_up_q[1];
	assign up_z  = out_up_q[2];
	assign degenerate = out_deg_q;

	// control word fetch and shared datapath logic
	always_comb begin
		w = ocs_pkg::rom_word(pc_q);
		for (int i = 0; i < 3; i++) begin
			d[i] = (QW+1)'(cen_q[i]) - (QW+1)'(e_q[i]);
			new_eye[i] = ocs_pkg::sat_q(64'(cen_q[i]) + 64'(dir_q[i]));
		end
		mul_a = '0;
		mul_b = '0;
		unique case (w.mul)
			ocs_pkg::M_NONE: begin
				mul_a = '0;
				mul_b = '0;
			end
			ocs_pkg::M_DXK: begin
				mul_a = 32'(dx_q);
				mul_b = 32'(ocs_pkg::SCALE_K);
			end
			ocs_pkg::M_DYK: begin
				mul_a = 32'(dy_q);
				mul_b = 32'(ocs_pkg::SCALE_K);
			end
			ocs_pkg::M_UFY: begin
				mul_a = 32'(up_q[w.ia]);
				mul_b = 32'(fdy_q);
			end
			ocs_pkg::M_SFX: begin
				mul_a = 32'(side_q[w.ia]);
				mul_b = 32'(fdx_q);
			end
			ocs_pkg::M_DU: begin
				mul_a = 32'(d[w.ia]);
				mul_b = 32'(up_q[w.ib]);
			end
			ocs_pkg::M_SD: begin
				mul_a = 32'(side_q[w.ia]);
				mul_b = 32'(d[w.ib]);
			end
			ocs_pkg::M_SQ: begin
				mul_a = $signed({2'b00, m_q[w.ia][MW-1:0]});
				mul_b = $signed({2'b00, m_q[w.ia][MW-1:0]});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod = 64'(mul_a) * 64'(mul_b);

		// square root step
		sq_bit = {{(RW-1){1'b0}}, 1'b1} << {cnt_q, 1'b0};
		sq_t   = r_q + sq_bit;
		sq_ge  = {1'b0, x_q} >= sq_t;

		// division step
		len   = r_q[LW-1:0];
		dv_t  = {rem_q[LW-1:0], num_q[cnt_q]};
		dv_ge = dv_t >= {1'b0, len};
		qn    = {q_q[UW-2:0], dv_ge};
		qext  = $signed({{(64-UW){1'b0}}, qn});
		div_val = ocs_pkg::sat_q(sg_q[w.ia] ? -qext : qext);
		num_init = {m_q[w.ia][MW-1:0], {FB{1'b0}}} + NW'(r_q[LW-1:1]);

		// magnitude reduction and zero tests
		big = (|m_q[0][VW-1:MW]) || (|m_q[1][VW-1:MW]) || (|m_q[2][VW-1:MW]);
		vzero = (v_q[0] == '0) && (v_q[1] == '0) && (v_q[2] == '0);
		out_free = !out_valid_q || out_ready;
	end

	// sequencer, camera state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pc_q        <= '0;
			ret_q       <= '0;
			dst_q       <= ocs_pkg::D_SIDE;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				cen_q[i] <= '0;
				eye_q[i] <= '0;
				up_q[i]  <= '0;
			end
			eye_q[2] <= ocs_pkg::NEG_ONE_Q;
			up_q[1]  <= ocs_pkg::ONE_Q;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					2'd0: cen_q[0] <= cfg_data;
					2'd1: cen_q[1] <= cfg_data;
					2'd2: cen_q[2] <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (!busy_q) begin
				if (in_valid) begin
					busy_q <= 1'b1;
					pc_q   <= '0;
				end
			end else begin
				pc_q <= pc_q + PW'(1);
				unique case (w.op)
					ocs_pkg::OP_MAG: begin
						if (vzero) begin
							pc_q <= w.tgt;
						end
					end
					ocs_pkg::OP_RED: begin
						if (big) begin
							pc_q <= pc_q;
						end
					end
					ocs_pkg::OP_SQS, ocs_pkg::OP_DVS: begin
						if (cnt_q != '0) begin
							pc_q <= pc_q;
						end
					end
					ocs_pkg::OP_CALL: begin
						ret_q <= pc_q + PW'(1);
						dst_q <= w.dst;
						pc_q  <= w.tgt;
					end
					ocs_pkg::OP_RET: begin
						pc_q <= ret_q;
					end
					ocs_pkg::OP_DONE: begin
						if (out_free) begin
							for (int i = 0; i < 3; i++) begin
								eye_q[i] <= new_eye[i];
								up_q[i]  <= upn_q[i];
							end
							busy_q      <= 1'b0;
							out_valid_q <= 1'b1;
						end else begin
							pc_q <= pc_q;
						end
					end
					ocs_pkg::OP_FAIL: begin
						if (out_free) begin
							busy_q      <= 1'b0;
							out_valid_q <= 1'b1;
						end else begin
							pc_q <= pc_q;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (!busy_q && in_valid) begin
			dx_q <= drag_x;
			dy_q <= drag_y;
		end
		if (busy_q) begin
			p_q <= prod;
			// target lanes of the product in flight: the operand lane, and the
			// cross product lane that neither operand index names
			wi_q <= w.ia;
			vi_q <= 2'd3 - w.ia - w.ib;

			// product write-back
			unique case (w.wb)
				ocs_pkg::W_NONE: ;
				ocs_pkg::W_FDX: fdx_q <= ocs_pkg::sat_q(p_q);
				ocs_pkg::W_FDY: fdy_q <= ocs_pkg::sat_q(p_q);
				ocs_pkg::W_EUP: e_q[wi_q] <= ocs_pkg::sat_q(64'(eye_q[wi_q]) + ocs_pkg::rnd_q(p_q));
				ocs_pkg::W_ESD: e_q[wi_q] <= ocs_pkg::sat_q(64'(e_q[wi_q]) - ocs_pkg::rnd_q(p_q));
				ocs_pkg::W_ACC: acc_q <= p_q[VW-1:0];
				ocs_pkg::W_VSB: v_q[vi_q] <= acc_q - $signed(p_q[VW-1:0]);
				ocs_pkg::W_SQ0: sum_q <= p_q[SW-1:0];
				ocs_pkg::W_SQA: sum_q <= sum_q + p_q[SW-1:0];
				default: ;
			endcase

			// sequencer operations
			unique case (w.op)
				ocs_pkg::OP_MAG: begin
					for (int i = 0; i < 3; i++) begin
						m_q[i]  <= VW'((v_q[i] < 0) ? -v_q[i] : v_q[i]);
						sg_q[i] <= v_q[i] < 0;
					end
				end
				ocs_pkg::OP_RED: begin
					if (big) begin
						for (int i = 0; i < 3; i++) begin
							m_q[i] <= m_q[i] >> 1;
						end
					end
				end
				ocs_pkg::OP_SQI: begin
					x_q   <= sum_q;
					r_q   <= '0;
					cnt_q <= CW'(ocs_pkg::SQRT_STEPS - 1);
				end
				ocs_pkg::OP_SQS: begin
					if (sq_ge) begin
						x_q <= x_q - sq_t[SW-1:0];
						r_q <= (r_q >> 1) + sq_bit;
					end else begin
						r_q <= r_q >> 1;
					end
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - CW'(1);
					end
				end
				ocs_pkg::OP_DVI: begin
					num_q <= num_init;
					rem_q <= (LW+1)'(num_init[NW-1:FB+1]);
					q_q   <= '0;
					cnt_q <= CW'(FB);
				end
				ocs_pkg::OP_DVS: begin
					rem_q <= dv_ge ? (dv_t - {1'b0, len}) : dv_t;
					q_q   <= qn;
					if (cnt_q != '0) begin
						cnt_q <= cnt_q - CW'(1);
					end else begin
						unique case (dst_q)
							ocs_pkg::D_SIDE: side_q[w.ia] <= div_val;
							ocs_pkg::D_UPN:  upn_q[w.ia]  <= div_val;
							ocs_pkg::D_DIR:  dir_q[w.ia]  <= div_val;
							default: ;
						endcase
					end
				end
				ocs_pkg::OP_LDDIR: begin
					for (int i = 0; i < 3; i++) begin
						v_q[i] <= VW'(e_q[i]) - VW'(cen_q[i]);
					end
				end
				ocs_pkg::OP_DONE: begin
					if (out_free) begin
						for (int i = 0; i < 3; i++) begin
							out_eye_q[i] <= new_eye[i];
							out_up_q[i]  <= upn_q[i];
						end
						out_deg_q <= 1'b0;
					end
				end
				ocs_pkg::OP_FAIL: begin
					if (out_free) begin
						for (int i = 0; i < 3; i++) begin
							out_eye_q[i] <= eye_q[i];
							out_up_q[i]  <= up_q[i];
						end
						out_deg_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// checks on the sequencer
	`ASSERT_NEXT(a_accept_starts, in_valid && in_ready, busy_q, "accepted item did not start the program")
	`ASSERT_HOLDS(a_pc_range, !busy_q || (pc_q < PW'(ocs_pkg::PROG_LEN)), "program counter out of range")
	`ASSERT_HOLDS(a_result_ends_run, $rose(out_valid_q) |-> $fell(busy_q), "result shown while still busy")
	`ASSERT_HOLDS(a_fail_keeps_eye, $rose(out_valid_q) && out_deg_q |-> $stable(eye_q[2]), "blocked update changed eye")

endmodule
